@@ hw/rtl/arcd_pkg.sv @@
`default_nettype none

package arcd_pkg;

	// store geometry
	localparam int DEPTH  = 64;
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W  = $clog2(DEPTH + 1);
	localparam int SUM_W  = CNT_W + 1;
	localparam int IDX_W  = 6;
	localparam int LEN_W  = 7;
	localparam int DATA_W = 32;
	localparam int CMP_W  = (CNT_W > IDX_W) ? CNT_W : IDX_W;

	typedef logic [ADDR_W-1:0] addr_t;
	typedef logic [CNT_W-1:0]  cnt_t;

	typedef enum logic [2:0] {
		OP_CLEAR     = 3'd0,
		OP_APPEND    = 3'd1,
		OP_READ      = 3'd2,
		OP_ROT_LEFT  = 3'd3,
		OP_ROT_RIGHT = 3'd4,
		OP_COUNT     = 3'd5,
		OP_DEL_FIRST = 3'd6,
		OP_DEL_ALL   = 3'd7
	} op_t;

	typedef enum logic [1:0] {
		STS_OK        = 2'd0,
		STS_NOT_FOUND = 2'd1,
		STS_FULL      = 2'd2,
		STS_INDEX     = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DISPATCH,
		S_RD_WAIT,
		S_ROT_WR,
		S_SWEEP,
		S_DRAIN,
		S_SETTLE,
		S_FINISH
	} state_t;

	typedef struct packed {
		op_t                      op;
		logic signed [DATA_W-1:0] value;
		logic [IDX_W-1:0]         index;
	} cmd_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] data;
		logic [LEN_W-1:0]         length;
		status_t                  status;
	} rsp_t;

	// controller -> datapath
	typedef struct packed {
		logic latch;
		logic clear;
		logic append;
		logic rd_issue;
		logic rd_take;
		logic rot_rd;
		logic rot_wr;
		logic sw_rd;
		logic sw_done;
		logic fin;
	} ctl_t;

	// datapath -> controller
	typedef struct packed {
		op_t  op;
		logic len_zero;
		logic len_gt1;
		logic idx_ok;
		logic sweep_last;
	} sts_t;

	// circular address: base + offset, modulo DEPTH (operands stay below 2*DEPTH)
	function automatic addr_t wrap_add(addr_t base, cnt_t off);
		logic [SUM_W-1:0] sum;
		sum = SUM_W'(base) + SUM_W'(off);
		if (sum >= SUM_W'(DEPTH)) begin
			sum = sum - SUM_W'(DEPTH);
		end
		return ADDR_W'(sum);
	endfunction

endpackage

`default_nettype wire

@@ hw/rtl/arcd_ctrl.sv @@
`default_nettype none

module arcd_ctrl
	import arcd_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic      in_ready,
	output logic      out_valid,
	input  wire logic out_ready,
	input  wire sts_t sts,
	output ctl_t      ctl
);

	state_t state_q, state_d;
	logic   out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (ctl.fin) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		ctl     = '0;
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					ctl.latch = 1'b1;
					state_d   = S_DISPATCH;
				end
			end
			S_DISPATCH: begin
				unique case (sts.op)
					OP_CLEAR: begin
						ctl.clear = 1'b1;
						state_d   = S_FINISH;
					end
					OP_APPEND: begin
						ctl.append = 1'b1;
						state_d    = S_FINISH;
					end
					OP_READ: begin
						ctl.rd_issue = 1'b1;
						state_d      = sts.idx_ok ? S_RD_WAIT : S_FINISH;
					end
					OP_ROT_LEFT, OP_ROT_RIGHT: begin
						if (sts.len_gt1) begin
							ctl.rot_rd = 1'b1;
							state_d    = S_ROT_WR;
						end else begin
							state_d = S_FINISH;
						end
					end
					OP_COUNT, OP_DEL_FIRST, OP_DEL_ALL: begin
						state_d = sts.len_zero ? S_SETTLE : S_SWEEP;
					end
					default: state_d = S_FINISH;
				endcase
			end
			S_RD_WAIT: begin
				ctl.rd_take = 1'b1;
				state_d     = S_FINISH;
			end
			S_ROT_WR: begin
				ctl.rot_wr = 1'b1;
				state_d    = S_FINISH;
			end
			S_SWEEP: begin
				ctl.sw_rd = 1'b1;
				if (sts.sweep_last) begin
					state_d = S_DRAIN;
				end
			end
			S_DRAIN: begin
				state_d = S_SETTLE;
			end
			S_SETTLE: begin
				ctl.sw_done = 1'b1;
				state_d     = S_FINISH;
			end
			S_FINISH: begin
				if (!out_valid_q || out_ready) begin
					ctl.fin = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

`ifndef SYNTH
	a_fin_slot_free: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.fin |-> (!out_valid_q || out_ready))
		else $error("result loaded over an untaken beat");

	a_valid_from_fin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(ctl.fin))
		else $error("output valid rose without a load");

	a_one_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({ctl.latch, ctl.clear, ctl.append, ctl.rd_issue, ctl.rd_take,
			ctl.rot_rd, ctl.rot_wr, ctl.sw_rd, ctl.sw_done, ctl.fin}))
		else $error("more than one datapath command in a cycle");
`endif

endmodule

`default_nettype wire

@@ hw/rtl/arcd_dpath.sv @@
`default_nettype none

module arcd_dpath
	import arcd_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire cmd_t in_data,
	input  wire ctl_t ctl,
	output sts_t      sts,
	output rsp_t      out_data
);

	logic signed [DATA_W-1:0] mem [DEPTH];

	cmd_t                     cmd_q;
	cnt_t                     len_q, r_q, w_q, acc_q;
	addr_t                    base_q;
	logic                     found_q;
	logic                     rd_vld_s1;
	logic signed [DATA_W-1:0] rd_data_s1;
	logic signed [DATA_W-1:0] res_data_q;
	status_t                  res_status_q;
	rsp_t                     out_q;

	logic                     full, idx_ok, is_count, match, drop, keep_wr;
	cnt_t                     rd_off, wr_off;
	addr_t                    rd_addr, wr_addr;
	logic                     rd_en, wr_en;
	logic signed [DATA_W-1:0] wr_data;

	assign full     = (len_q == CNT_W'(DEPTH));
	assign idx_ok   = (CMP_W'(cmd_q.index) < CMP_W'(len_q));
	assign is_count = (cmd_q.op == OP_COUNT);
	assign match    = (rd_data_s1 == cmd_q.value);
	assign drop     = match && ((cmd_q.op == OP_DEL_ALL) ||
		((cmd_q.op == OP_DEL_FIRST) && !found_q));
	assign keep_wr  = rd_vld_s1 && !is_count && !drop;

	// read port: logical offset from base
	always_comb begin
		if (ctl.rd_issue) begin
			rd_off = CNT_W'(cmd_q.index);
		end else if (ctl.rot_rd) begin
			rd_off = (cmd_q.op == OP_ROT_LEFT) ? '0 : len_q - cnt_t'(1);
		end else begin
			rd_off = r_q;
		end
	end
	assign rd_addr = wrap_add(base_q, rd_off);
	assign rd_en   = ctl.rd_issue || ctl.rot_rd || ctl.sw_rd;

	// write port
	always_comb begin
		wr_en   = 1'b0;
		wr_off  = w_q;
		wr_data = rd_data_s1;
		if (ctl.append) begin
			wr_en   = !full;
			wr_off  = len_q;
			wr_data = cmd_q.value;
		end else if (ctl.rot_wr) begin
			wr_en  = 1'b1;
			wr_off = (cmd_q.op == OP_ROT_LEFT) ? len_q : CNT_W'(DEPTH - 1);
		end else if (keep_wr) begin
			wr_en = 1'b1;
		end
	end
	assign wr_addr = wrap_add(base_q, wr_off);

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_s1 <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_q     <= '0;
			len_q     <= '0;
			base_q    <= '0;
			r_q       <= '0;
			w_q       <= '0;
			acc_q     <= '0;
			found_q   <= 1'b0;
			rd_vld_s1 <= 1'b0;
		end else begin
			rd_vld_s1 <= ctl.sw_rd;
			if (ctl.latch) begin
				cmd_q   <= in_data;
				r_q     <= '0;
				w_q     <= '0;
				acc_q   <= '0;
				found_q <= 1'b0;
			end
			if (ctl.clear) begin
				len_q <= '0;
			end
			if (ctl.append && !full) begin
				len_q <= len_q + cnt_t'(1);
			end
			if (ctl.rot_wr) begin
				base_q <= (cmd_q.op == OP_ROT_LEFT) ? wrap_add(base_q, cnt_t'(1))
				                                    : wrap_add(base_q, CNT_W'(DEPTH - 1));
			end
			if (ctl.sw_rd) begin
				r_q <= r_q + cnt_t'(1);
			end
			if (rd_vld_s1) begin
				if (is_count) begin
					acc_q <= acc_q + cnt_t'(match);
				end else if (drop) begin
					acc_q   <= acc_q + cnt_t'(1);
					found_q <= 1'b1;
				end else begin
					w_q <= w_q + cnt_t'(1);
				end
			end
			if (ctl.sw_done && !is_count) begin
				len_q <= w_q;
			end
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (ctl.latch) begin
			res_data_q   <= '0;
			res_status_q <= STS_OK;
		end
		if (ctl.append && full) begin
			res_status_q <= STS_FULL;
		end
		if (ctl.rd_issue && !idx_ok) begin
			res_status_q <= STS_INDEX;
		end
		if (ctl.rd_take) begin
			res_data_q <= rd_data_s1;
		end
		if (ctl.sw_done) begin
			res_data_q <= DATA_W'(acc_q);
			if (!is_count && (acc_q == '0)) begin
				res_status_q <= STS_NOT_FOUND;
			end
		end
		if (ctl.fin) begin
			out_q.data   <= res_data_q;
			out_q.length <= LEN_W'(len_q);
			out_q.status <= res_status_q;
		end
	end

	assign sts.op         = cmd_q.op;
	assign sts.len_zero   = (len_q == '0);
	assign sts.len_gt1    = (len_q > cnt_t'(1));
	assign sts.idx_ok     = idx_ok;
	assign sts.sweep_last = ((r_q + cnt_t'(1)) == len_q);
	assign out_data       = out_q;

`ifndef SYNTH
	a_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		len_q <= CNT_W'(DEPTH))
		else $error("length beyond store depth");

	a_wr_behind_rd: assert property (@(posedge clk) disable iff (!arst_n)
		rd_vld_s1 |-> (w_q < r_q))
		else $error("compaction write pointer caught up with read pointer");

	a_sweep_balance: assert property (@(posedge clk) disable iff (!arst_n)
		(!rd_vld_s1 && (cmd_q.op != OP_COUNT)) |-> ((acc_q + w_q) == r_q))
		else $error("kept plus removed entries differ from entries swept");
`endif

endmodule

`default_nettype wire

@@ hw/rtl/array_rotate_count_delete_engine_core.sv @@
// Array rotate / count / delete engine. Holds up to DEPTH (64) signed 32-bit
// words in a circular store addressed from a base pointer, plus a length.
// One command beat in gives exactly one result beat out (data, length, status).
// From acceptance to the load of the result register, output register free:
// clear and append dispatch, then load; read issues one registered RAM read,
// then takes its word (skipped when the index is beyond the length); rotate
// moves the base pointer and relocates a single word, so it does not depend
// on length (skipped when fewer than two words are stored); count / delete
// first / delete all sweep, drain and settle (only settle on an empty store):
// the store has one read and one write port, and these commands sweep every
// stored word through them, one per cycle, the deletes compacting in place
// behind the read pointer. The engine is idle again the cycle after the
// load, so the next command beat can be taken then, even while that result
// beat is still waiting on out_ready; if the output register is still full
// when the next result is ready, the engine holds until it drains. No
// clearing pass after reset: words above the length never reach a result.
`default_nettype none

module array_rotate_count_delete_engine_core
	import arcd_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,

	// command beats
	input  wire logic in_valid,
	output logic      in_ready,
	input  wire cmd_t in_data,

	// result beats
	output logic      out_valid,
	input  wire logic out_ready,
	output rsp_t      out_data
);

	ctl_t ctl;
	sts_t sts;

	// sequencing: accept, dispatch by op, sweep, settle, load result
	arcd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.ctl       (ctl)
	);

	// store, pointers, match/compaction logic, output register
	arcd_dpath u_dpath (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_data  (in_data),
		.ctl      (ctl),
		.sts      (sts),
		.out_data (out_data)
	);

endmodule

`default_nettype wire

@@ test/array_rotate_count_delete_engine_core_tb.sv @@
`timescale 1ns / 1ps

module array_rotate_count_delete_engine_core_tb;
	import arcd_pkg::*;

	// run shape
	localparam int RANDOM_BEATS = 1525;
	localparam int LONG_HOLD    = 400;      // receiver hold-off, in cycles
	localparam int TAIL_CYCLES  = 120;      // longer than the longest sweep, plus slack
	localparam int CYCLE_LIMIT  = 1000000;

	// one row of the directed script; "typed" rows carry a hand-written result
	typedef struct {
		cmd_t cmd;
		bit   typed;
		rsp_t want;
	} script_row_t;

	logic clk       = 1'b0;
	logic arst_n    = 1'b0;
	logic in_valid  = 1'b0;
	logic in_ready;
	cmd_t in_data   = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	rsp_t out_data;

	// shadow of the engine: stored words and current length
	logic signed [DATA_W-1:0] shadow_words [DEPTH];
	int                       shadow_len = 0;

	rsp_t pending_rsp [$];       // results owed by the engine, oldest first
	int   bad_count   = 0;
	int   rsp_seen    = 0;
	int   cycle_cnt   = 0;
	bit   hold_off_req = 1'b0;   // main asks the receiver for one long hold-off

	// random shaping
	bit                       fill_mode = 1'b1;
	int                       full_hits = 0;
	logic signed [DATA_W-1:0] value_pool [4];

	array_rotate_count_delete_engine_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	always #5 clk = ~clk;

	// ------------------------------------------------------------------
	// Shadow engine: applies one command, returns the result beat it owes.
	// ------------------------------------------------------------------
	function automatic rsp_t engine_apply(input cmd_t c);
		rsp_t                     r;
		logic signed [DATA_W-1:0] keep;
		int                       i;
		int                       w;
		int                       hit;
		r.data   = '0;
		r.status = STS_OK;
		case (c.op)
			OP_CLEAR: begin
				shadow_len = 0;
			end
			OP_APPEND: begin
				if (shadow_len >= DEPTH) begin
					r.status = STS_FULL;
				end else begin
					shadow_words[shadow_len] = c.value;
					shadow_len++;
				end
			end
			OP_READ: begin
				if (int'(c.index) < shadow_len) begin
					r.data = shadow_words[c.index];
				end else begin
					r.status = STS_INDEX;
				end
			end
			OP_ROT_LEFT: begin
				if (shadow_len > 1) begin
					keep = shadow_words[0];
					for (i = 0; i + 1 < shadow_len; i++)
						shadow_words[i] = shadow_words[i + 1];
					shadow_words[shadow_len - 1] = keep;
				end
			end
			OP_ROT_RIGHT: begin
				if (shadow_len > 1) begin
					keep = shadow_words[shadow_len - 1];
					for (i = shadow_len - 1; i > 0; i--)
						shadow_words[i] = shadow_words[i - 1];
					shadow_words[0] = keep;
				end
			end
			OP_COUNT: begin
				hit = 0;
				for (i = 0; i < shadow_len; i++)
					if (shadow_words[i] == c.value)
						hit++;
				r.data = hit;
			end
			OP_DEL_FIRST: begin
				hit = -1;
				for (i = 0; i < shadow_len && hit < 0; i++)
					if (shadow_words[i] == c.value)
						hit = i;
				if (hit < 0) begin
					r.status = STS_NOT_FOUND;
				end else begin
					// close the gap; the last word survives
					for (i = hit; i + 1 < shadow_len; i++)
						shadow_words[i] = shadow_words[i + 1];
					shadow_len--;
					r.data = 1;
				end
			end
			default: begin
				// delete all: order-preserving compaction
				w = 0;
				for (i = 0; i < shadow_len; i++) begin
					if (shadow_words[i] != c.value) begin
						shadow_words[w] = shadow_words[i];
						w++;
					end
				end
				r.data     = shadow_len - w;
				shadow_len = w;
				if (r.data == 0)
					r.status = STS_NOT_FOUND;
			end
		endcase
		r.length = LEN_W'(shadow_len);
		return r;
	endfunction

	task automatic report_mismatch(input string msg);
		$display("MISMATCH @%0t: %s", $realtime, msg);
		bad_count++;
	endtask

	// ------------------------------------------------------------------
	// Command side. Valid goes up at a rising edge and stays up until the
	// beat is taken; in_ready is read right after the edge, so it holds
	// its pre-edge value. The shadow is updated at the accepting edge.
	// ------------------------------------------------------------------
	task automatic send_cmd(input cmd_t c, input bit typed, input rsp_t want);
		rsp_t predicted;
		in_valid <= 1'b1;
		in_data  <= c;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		predicted = engine_apply(c);
		pending_rsp.push_back(typed ? want : predicted);
	endtask

	// stop offering and wait until every owed result beat has come back
	task automatic drain_wait();
		in_valid <= 1'b0;
		while (pending_rsp.size() != 0)
			@(posedge clk);
	endtask

	// mostly drawn from a small pool so count/delete find matches
	function automatic logic signed [DATA_W-1:0] pick_value();
		if ($urandom_range(0, 9) < 6)
			return value_pool[$urandom_range(0, 3)];
		return $urandom;
	endfunction

	function automatic logic signed [DATA_W-1:0] pick_target();
		if (shadow_len > 0 && $urandom_range(0, 9) < 7)
			return shadow_words[$urandom_range(0, shadow_len - 1)];
		return pick_value();
	endfunction

	function automatic void refresh_pool();
		int k;
		for (k = 0; k < 4; k++) begin
			case ($urandom_range(0, 5))
				0:       value_pool[k] = 32'sh0000_0000;
				1:       value_pool[k] = -32'sd1;
				2:       value_pool[k] = 32'sh8000_0000;
				3:       value_pool[k] = 32'sh7fff_ffff;
				default: value_pool[k] = $urandom;
			endcase
		end
	endfunction

	// next random command; fill episodes drive the store up to capacity
	// and a few beats past it, the rest is a mix that also drains it
	function automatic cmd_t next_cmd();
		cmd_t c;
		int   roll;
		c.value = $urandom;
		c.index = IDX_W'($urandom_range(0, 63));
		roll    = $urandom_range(0, 99);
		if (fill_mode && roll < 85) begin
			c.op    = OP_APPEND;
			c.value = pick_value();
			if (shadow_len >= DEPTH)
				full_hits++;
			if (full_hits >= 3) begin
				fill_mode = 1'b0;
				full_hits = 0;
			end
			return c;
		end
		roll = $urandom_range(0, 99);
		if (roll < 2) begin
			c.op = OP_CLEAR;
		end else if (roll < 32) begin
			c.op    = OP_APPEND;
			c.value = pick_value();
		end else if (roll < 47) begin
			c.op = OP_READ;
			if (shadow_len > 0 && $urandom_range(0, 3) != 0)
				c.index = IDX_W'($urandom_range(0, shadow_len - 1));
		end else if (roll < 55) begin
			c.op = OP_ROT_LEFT;
		end else if (roll < 63) begin
			c.op = OP_ROT_RIGHT;
		end else if (roll < 75) begin
			c.op    = OP_COUNT;
			c.value = pick_target();
		end else if (roll < 88) begin
			c.op    = OP_DEL_FIRST;
			c.value = pick_target();
		end else begin
			c.op    = OP_DEL_ALL;
			c.value = pick_target();
		end
		return c;
	endfunction

	function automatic void add_row(ref script_row_t rows[$], input op_t op,
			input logic signed [DATA_W-1:0] value, input logic [IDX_W-1:0] index,
			input bit typed, input logic signed [DATA_W-1:0] data = '0,
			input int len = 0, input status_t st = STS_OK);
		script_row_t r;
		r.cmd.op       = op;
		r.cmd.value    = value;
		r.cmd.index    = index;
		r.typed        = typed;
		r.want.data    = data;
		r.want.length  = LEN_W'(len);
		r.want.status  = st;
		rows.push_back(r);
	endfunction

	// ------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------
	initial begin : main_seq
		script_row_t script [$];
		rsp_t        none;
		int          sent;
		int          burst;
		int          gap;
		int          k;
		bit          did_hold;
		bit          did_drain;

		none      = '0;
		did_hold  = 1'b0;
		did_drain = 1'b0;
		refresh_pool();

		// empty store: every command that looks at the words sees nothing
		add_row(script, OP_READ,      32'sd0,   6'd0,  1, 0, 0, STS_INDEX);
		add_row(script, OP_ROT_LEFT,  32'sd7,   6'd0,  1, 0, 0, STS_OK);
		add_row(script, OP_ROT_RIGHT, 32'sd7,   6'd0,  1, 0, 0, STS_OK);
		add_row(script, OP_COUNT,     32'sd0,   6'd0,  1, 0, 0, STS_OK);
		add_row(script, OP_DEL_FIRST, 32'sd5,   6'd0,  1, 0, 0, STS_NOT_FOUND);
		add_row(script, OP_DEL_ALL,   32'sd5,   6'd0,  1, 0, 0, STS_NOT_FOUND);
		// single word: rotations leave it alone
		add_row(script, OP_APPEND,    32'sh8000_0000, 6'd63, 1, 0, 1, STS_OK);
		add_row(script, OP_ROT_LEFT,  32'sd0,   6'd0,  1, 0, 1, STS_OK);
		add_row(script, OP_ROT_RIGHT, 32'sd0,   6'd0,  1, 0, 1, STS_OK);
		add_row(script, OP_READ,      32'sd0,   6'd0,  1, 32'sh8000_0000, 1, STS_OK);
		// store = min, max, min, -1
		add_row(script, OP_APPEND,    32'sh7fff_ffff, 6'd0, 1, 0, 2, STS_OK);
		add_row(script, OP_APPEND,    32'sh8000_0000, 6'd0, 1, 0, 3, STS_OK);
		add_row(script, OP_APPEND,    -32'sd1,  6'd0,  1, 0, 4, STS_OK);
		add_row(script, OP_READ,      32'sd0,   6'd63, 1, 0, 4, STS_INDEX);
		add_row(script, OP_COUNT,     32'sh8000_0000, 6'd0, 1, 2, 4, STS_OK);
		add_row(script, OP_ROT_LEFT,  32'sd0,   6'd0,  1, 0, 4, STS_OK);
		add_row(script, OP_READ,      32'sd0,   6'd0,  0);
		add_row(script, OP_ROT_RIGHT, 32'sd0,   6'd0,  1, 0, 4, STS_OK);
		// delete first must keep the last word
		add_row(script, OP_DEL_FIRST, 32'sh8000_0000, 6'd0, 1, 1, 3, STS_OK);
		add_row(script, OP_READ,      32'sd0,   6'd2,  0);
		add_row(script, OP_APPEND,    32'sh8000_0000, 6'd0, 1, 0, 4, STS_OK);
		add_row(script, OP_DEL_ALL,   32'sh8000_0000, 6'd0, 0);
		add_row(script, OP_READ,      32'sd0,   6'd1,  0);
		// clear hides the words
		add_row(script, OP_CLEAR,     32'sd0,   6'd0,  1, 0, 0, STS_OK);
		add_row(script, OP_READ,      32'sd0,   6'd0,  1, 0, 0, STS_INDEX);

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (script[i]) begin
			send_cmd(script[i].cmd, script[i].typed, script[i].want);
			gap = $urandom_range(0, 2);
			if (gap != 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		drain_wait();

		// random part, sent in bursts
		sent = 0;
		while (sent < RANDOM_BEATS) begin
			burst = $urandom_range(1, 24);
			for (k = 0; k < burst && sent < RANDOM_BEATS; k++) begin
				if (!fill_mode && $urandom_range(0, 299) == 0) begin
					fill_mode = 1'b1;
					refresh_pool();
				end
				send_cmd(next_cmd(), 1'b0, none);
				sent++;
				// receiver sits on its output while commands keep coming
				if (!did_hold && sent == 500)
					hold_off_req = 1'b1;
			end
			if (!did_drain && sent >= 1000) begin
				did_drain = 1'b1;
				drain_wait();
			end else begin
				// a quarter of the bursts run back to back
				gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
				if (gap != 0) begin
					in_valid <= 1'b0;
					repeat (gap) @(posedge clk);
				end
			end
			if (sent >= 500)
				did_hold = 1'b1;
		end

		drain_wait();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (bad_count == 0) begin
			$display("array_rotate_count_delete_engine_core_tb OK");
		end else begin
			$display("array_rotate_count_delete_engine_core_tb NOT OK");
		end
		$finish;
	end

	// ------------------------------------------------------------------
	// Result side: out_ready follows a pattern of its own, switching
	// between always-ready, coin-flip and periodic on/off stretches.
	// ------------------------------------------------------------------
	initial begin : rx_side
		int mode;
		int span;
		int on_len;
		int off_len;
		int k;
		@(posedge clk);
		while (!arst_n)
			@(posedge clk);
		forever begin
			if (hold_off_req) begin
				out_ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
				hold_off_req = 1'b0;
			end
			mode    = $urandom_range(0, 2);
			span    = $urandom_range(20, 200);
			on_len  = $urandom_range(1, 6);
			off_len = $urandom_range(1, 6);
			for (k = 0; k < span && !hold_off_req; k++) begin
				case (mode)
					0:       out_ready <= 1'b1;
					1:       out_ready <= 1'($urandom_range(0, 1));
					default: out_ready <= (k % (on_len + off_len)) < on_len;
				endcase
				@(posedge clk);
			end
		end
	end

	// ------------------------------------------------------------------
	// Checker: every accepted result beat against the oldest owed one
	// ------------------------------------------------------------------
	always @(posedge clk) begin : rsp_check
		rsp_t want;
		if (arst_n && out_valid && out_ready) begin
			rsp_seen++;
			if (pending_rsp.size() == 0) begin
				report_mismatch($sformatf("result beat %0d with nothing owed", rsp_seen));
			end else begin
				want = pending_rsp.pop_front();
				if (out_data.data !== want.data)
					report_mismatch($sformatf("beat %0d data %h want %h",
						rsp_seen, out_data.data, want.data));
				if (out_data.length !== want.length)
					report_mismatch($sformatf("beat %0d length %0d want %0d",
						rsp_seen, out_data.length, want.length));
				if (out_data.status !== want.status)
					report_mismatch($sformatf("beat %0d status %0d want %0d",
						rsp_seen, out_data.status, want.status));
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt >= CYCLE_LIMIT) begin
			$display("TIMEOUT after %0d cycles, %0d results owed", cycle_cnt,
				pending_rsp.size());
			$display("array_rotate_count_delete_engine_core_tb NOT OK");
			$finish;
		end
	end

endmodule

@@ array_rotate_count_delete_engine_core.f @@
hw/rtl/arcd_pkg.sv
hw/rtl/arcd_ctrl.sv
hw/rtl/arcd_dpath.sv
hw/rtl/array_rotate_count_delete_engine_core.sv
test/array_rotate_count_delete_engine_core_tb.sv
